### rtl/core/tnmad_pkg.sv
`timescale 1ns / 1ps
// Shared widths, constants and types for the temporal noise metric block.
// No dependencies.
package tnmad_pkg;

  localparam int SAMPLE_W   = 8;
  localparam int FRAME_W    = 5;
  localparam int MAX_FRAMES = 16;
  localparam int SUM_W      = 12;
  localparam int SCALE_W    = 13;
  localparam int PIX_W      = 23;
  localparam int MAX_PIXELS = 4194304;
  localparam int TOTAL_W    = 40;
  localparam int NSQ_W      = 9;
  localparam int DEN_W      = 31;
  localparam int METRIC_W   = 24;
  localparam int FRAC_W     = 16;
  localparam int INT_W      = METRIC_W - FRAC_W;
  localparam int STEP_W     = $clog2(METRIC_W);

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic load;
    logic drain;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_SQUARE,
    ST_SCALE,
    ST_DIVIDE
  } state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_PREP,
    DV_RUN
  } div_state_t;

endpackage

### rtl/core/temporal_noise_mean_abs_deviation.sv
`timescale 1ns / 1ps
// Temporal noise metric top level: cell row, deviation accumulator, divider.
// Uses tnmad_pkg, tnmad_cell, tnmad_div.
//
// Each sample word is taken while start is high and busy low, and shifted
// into a row of 16 cells. When a pixel has its N words, busy rises while
// the row drains one sample a cycle into the deviation accumulator. On the
// pixel flagged last, the SQUARE and SCALE states form the divisor and the
// one-bit-per-cycle divider runs (it stops early when the metric
// saturates); then out_valid pulses for one cycle with the metric and
// pixel count; the receiver must take it then. No clearing pass after
// reset.
module temporal_noise_mean_abs_deviation
  import tnmad_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                in_last_pixel,
  output logic                out_valid,
  output logic [METRIC_W-1:0] out_noise_metric,
  output logic [PIX_W-1:0]    out_pixel_count,
  input  logic                cfg_we,
  input  logic [FRAME_W-1:0]  cfg_wdata
);

  state_t state_r, state_nxt;

  logic [FRAME_W-1:0]  frame_count_r, frame_count_nxt;
  logic [FRAME_W-1:0]  idx_r, idx_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [FRAME_W-1:0]  cnt_r, cnt_nxt;
  logic [FRAME_W-1:0]  rem_r, rem_nxt;
  logic                last_r, last_nxt;
  logic                add_en_r, add_en_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic [PIX_W-1:0]    pixels_r, pixels_nxt;
  logic [NSQ_W-1:0]    nsq_r, nsq_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [METRIC_W-1:0] metric_r, metric_nxt;
  logic [PIX_W-1:0]    count_r, count_nxt;

  logic [FRAME_W-1:0]  n_eff;
  logic [FRAME_W-1:0]  idx_inc;
  logic                accept;
  logic                complete;
  logic [SCALE_W-1:0]  scaled;
  logic [SCALE_W-1:0]  dev;
  logic [NSQ_W+PIX_W-1:0] den_full;
  cell_ctrl_t          cell_ctrl;
  logic                div_start;
  logic                div_done;
  logic [METRIC_W-1:0] div_quot;
  sample_t             cell_q [MAX_FRAMES];

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    sample_t left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = in_sample;
    end else begin : g_mid
      assign left_w = cell_q[i-1];
    end
    if (i == MAX_FRAMES - 1) begin : g_end
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = cell_q[i+1];
    end
    tnmad_cell u_cell (
      .clk     (clk),
      .ctrl    (cell_ctrl),
      .left_i  (left_w),
      .right_i (right_w),
      .q       (cell_q[i])
    );
  end

  assign den_full = (NSQ_W+PIX_W)'(nsq_r) * (NSQ_W+PIX_W)'(pixels_r);

  tnmad_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (total_r),
    .den   (den_full[DEN_W-1:0]),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    n_eff = frame_count_r;
    if (frame_count_r == '0) begin
      n_eff = FRAME_W'(1);
    end else if (frame_count_r > FRAME_W'(MAX_FRAMES)) begin
      n_eff = FRAME_W'(MAX_FRAMES);
    end
  end

  assign accept   = start && !busy;
  assign idx_inc  = idx_r + FRAME_W'(1);
  assign complete = idx_inc >= n_eff;
  assign scaled   = SCALE_W'(cnt_r) * SCALE_W'(cell_q[0]);
  assign dev      = (scaled >= SCALE_W'(sum_r)) ? scaled - SCALE_W'(sum_r)
                                                : SCALE_W'(sum_r) - scaled;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (accept && complete) state_nxt = ST_DRAIN;
      ST_DRAIN: begin
        if (rem_r == FRAME_W'(1)) begin
          state_nxt = last_r ? ST_SQUARE : ST_IDLE;
        end
      end
      ST_SQUARE: state_nxt = ST_SCALE;
      ST_SCALE:  state_nxt = ST_DIVIDE;
      ST_DIVIDE: if (div_done) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy            = 1'b1;
    cell_ctrl.drain = 1'b0;
    div_start       = 1'b0;
    case (state_r)
      ST_IDLE:  busy            = 1'b0;
      ST_DRAIN: cell_ctrl.drain = 1'b1;
      ST_SCALE: div_start       = 1'b1;
      default:  ;
    endcase
    cell_ctrl.load = start && (state_r == ST_IDLE);
  end

  always_comb begin
    frame_count_nxt = cfg_we ? cfg_wdata : frame_count_r;
    idx_nxt         = idx_r;
    sum_nxt         = sum_r;
    cnt_nxt         = cnt_r;
    rem_nxt         = rem_r;
    last_nxt        = last_r;
    add_en_nxt      = add_en_r;
    total_nxt       = total_r;
    pixels_nxt      = pixels_r;
    nsq_nxt         = nsq_r;
    out_valid_nxt   = 1'b0;
    metric_nxt      = metric_r;
    count_nxt       = count_r;

    if (accept) begin
      sum_nxt = sum_r + SUM_W'(in_sample);
      idx_nxt = idx_inc;
      if (complete) begin
        idx_nxt    = '0;
        cnt_nxt    = idx_inc;
        rem_nxt    = idx_inc;
        last_nxt   = in_last_pixel;
        add_en_nxt = pixels_r < PIX_W'(MAX_PIXELS);
        if (pixels_r < PIX_W'(MAX_PIXELS)) begin
          pixels_nxt = pixels_r + PIX_W'(1);
        end
      end
    end

    if (state_r == ST_DRAIN) begin
      rem_nxt = rem_r - FRAME_W'(1);
      if (add_en_r) begin
        total_nxt = total_r + TOTAL_W'(dev);
      end
      if (rem_r == FRAME_W'(1)) begin
        sum_nxt = '0;
      end
    end

    if (state_r == ST_SQUARE) begin
      nsq_nxt = NSQ_W'(n_eff) * NSQ_W'(n_eff);
    end

    if (state_r == ST_DIVIDE && div_done) begin
      out_valid_nxt = 1'b1;
      metric_nxt    = div_quot;
      count_nxt     = pixels_r;
      total_nxt     = '0;
      pixels_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      frame_count_r <= FRAME_W'(1);
      idx_r         <= '0;
      sum_r         <= '0;
      total_r       <= '0;
      pixels_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      frame_count_r <= frame_count_nxt;
      idx_r         <= idx_nxt;
      sum_r         <= sum_nxt;
      total_r       <= total_nxt;
      pixels_r      <= pixels_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    rem_r    <= rem_nxt;
    last_r   <= last_nxt;
    add_en_r <= add_en_nxt;
    nsq_r    <= nsq_nxt;
    metric_r <= metric_nxt;
    count_r  <= count_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_noise_metric = metric_r;
  assign out_pixel_count  = count_r;

endmodule

### rtl/core/tnmad_cell.sv
`timescale 1ns / 1ps
// One sample cell of the frame row: loads from the left neighbor,
// drains by taking the right neighbor's value. Uses tnmad_pkg.
module tnmad_cell
  import tnmad_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  sample_t    left_i,
  input  sample_t    right_i,
  output sample_t    q
);

  sample_t val_r;
  sample_t val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.load) begin
      val_nxt = left_i;
    end else if (ctrl.drain) begin
      val_nxt = right_i;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign q = val_r;

endmodule

### rtl/core/tnmad_div.sv
`timescale 1ns / 1ps
// Radix-2 restoring divider for the Q8.16 metric, one quotient bit a cycle,
// saturating to all ones. Uses tnmad_pkg.
module tnmad_div
  import tnmad_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [TOTAL_W-1:0]  num,
  input  logic [DEN_W-1:0]    den,
  output logic                done,
  output logic [METRIC_W-1:0] quot
);

  div_state_t state_r, state_nxt;

  logic [TOTAL_W-1:0]  num_r, num_nxt;
  logic [DEN_W-1:0]    den_r, den_nxt;
  logic [DEN_W-1:0]    rem_r, rem_nxt;
  logic [METRIC_W-1:0] lo_r, lo_nxt;
  logic [METRIC_W-1:0] quot_r, quot_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                done_r, done_nxt;

  logic                sat;
  logic                last_step;
  logic [DEN_W:0]      trial;
  logic [DEN_W:0]      diff;
  logic                ge;
  logic                prep, run;

  assign sat       = num_r >= TOTAL_W'({den_r, {INT_W{1'b0}}});
  assign last_step = step_r == STEP_W'(METRIC_W - 1);
  assign trial     = {rem_r, lo_r[METRIC_W-1]};
  assign diff      = trial - {1'b0, den_r};
  assign ge        = trial >= {1'b0, den_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      DV_IDLE: if (start) state_nxt = DV_PREP;
      DV_PREP: state_nxt = sat ? DV_IDLE : DV_RUN;
      DV_RUN:  if (last_step) state_nxt = DV_IDLE;
      default: state_nxt = DV_IDLE;
    endcase
  end

  always_comb begin
    prep = 1'b0;
    run  = 1'b0;
    case (state_r)
      DV_PREP: prep = 1'b1;
      DV_RUN:  run  = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    quot_nxt = quot_r;
    step_nxt = step_r;
    done_nxt = 1'b0;
    if (state_r == DV_IDLE && start) begin
      num_nxt = num;
      den_nxt = den;
    end
    if (prep) begin
      step_nxt = '0;
      rem_nxt  = num_r[DEN_W+INT_W-1:INT_W];
      lo_nxt   = {num_r[INT_W-1:0], {FRAC_W{1'b0}}};
      if (sat) begin
        quot_nxt = '1;
        done_nxt = 1'b1;
      end
    end
    if (run) begin
      rem_nxt  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      lo_nxt   = {lo_r[METRIC_W-2:0], 1'b0};
      quot_nxt = {quot_r[METRIC_W-2:0], ge};
      step_nxt = step_r + STEP_W'(1);
      done_nxt = last_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    lo_r   <= lo_nxt;
    quot_r <= quot_nxt;
    step_r <= step_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule
